// ===== rtl/assembly_line_tokenizer_defines.svh =====
// assertion macros for the assembly line tokenizer
`ifndef ASSEMBLY_LINE_TOKENIZER_DEFINES_SVH
`define ASSEMBLY_LINE_TOKENIZER_DEFINES_SVH

// condition in the same cycle
`define ALT_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// condition in the following cycle
`define ALT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/alt_pkg.sv =====
// shared types, constants and helpers of the assembly line tokenizer
`default_nettype none

package alt_pkg;

    localparam int LINE_CAP_DEF     = 128;
    localparam int MAX_OPERANDS_DEF = 16;

    localparam int CHAR_W   = 8;
    localparam int MAXNS_W  = 7;
    localparam int MAXLAB_W = 6;
    localparam int APB_DW   = 32;
    localparam int APB_AW   = 3;

    localparam int STATUS_W = 2;
    localparam int KIND_W   = 3;
    localparam int OPIDX_W  = 4;
    localparam int START_W  = 7;
    localparam int END_W    = 8;
    localparam int KEPT_W   = 8;
    localparam int COUNT_W  = 5;
    localparam int TDATA_W  = 40;
    localparam int TDATA_PAD = TDATA_W - (STATUS_W + OPIDX_W + START_W + END_W + KEPT_W
                                          + COUNT_W);

    localparam logic [MAXNS_W-1:0]  MAX_NONSPACE_RST = 7'd80;
    localparam logic [MAXLAB_W-1:0] MAX_LABEL_RST    = 6'd31;

    // register index, taken from paddr[2]
    localparam logic REG_MAX_NONSPACE = 1'b0;
    localparam logic REG_MAX_LABEL    = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_SYNTAX   = 2'd2;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd3;

    localparam logic [KIND_W-1:0] KIND_NONE     = 3'd0;
    localparam logic [KIND_W-1:0] KIND_LABEL    = 3'd1;
    localparam logic [KIND_W-1:0] KIND_INSTR    = 3'd2;
    localparam logic [KIND_W-1:0] KIND_DIRECT   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_OPERAND  = 3'd4;

    localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
    localparam logic [CHAR_W-1:0] CH_SEMI  = 8'h3B;
    localparam logic [CHAR_W-1:0] CH_COLON = 8'h3A;
    localparam logic [CHAR_W-1:0] CH_COMMA = 8'h2C;
    localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2E;
    localparam logic [CHAR_W-1:0] CH_QUOTE = 8'h22;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [KIND_W-1:0]   token_kind;
        logic [OPIDX_W-1:0]  operand_index;
        logic [START_W-1:0]  token_start;
        logic [END_W-1:0]    token_end;
        logic [KEPT_W-1:0]   kept_length;
        logic [COUNT_W-1:0]  operand_count;
        logic                last;
    } alt_result_t;

    function automatic logic is_ws(input logic [CHAR_W-1:0] c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

endpackage

`default_nettype wire

// ===== rtl/alt_line_buf.sv =====
// line buffer memory with fill count and overflow flag
`default_nettype none

module alt_line_buf #(
    parameter int LINE_CAP = alt_pkg::LINE_CAP_DEF
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              wr_en,
    input  wire logic [alt_pkg::CHAR_W-1:0]        wr_char,
    input  wire logic                              line_clear,
    input  wire logic [$clog2(LINE_CAP)-1:0]       rd_addr,
    output logic      [alt_pkg::CHAR_W-1:0]        rd_data,
    output logic      [$clog2(LINE_CAP+1)-1:0]     fill,
    output logic                                   overflowed
);

    localparam int IDX_W  = $clog2(LINE_CAP);
    localparam int FILL_W = $clog2(LINE_CAP + 1);

    logic [alt_pkg::CHAR_W-1:0] line_store_mem [LINE_CAP];
    logic [alt_pkg::CHAR_W-1:0] rd_data_reg;
    logic [FILL_W-1:0]          fill_reg, fill_next;
    logic                       ovf_reg, ovf_next;
    logic                       store_en;

    always_comb begin
        fill_next = fill_reg;
        ovf_next  = ovf_reg;
        store_en  = 1'b0;
        if (line_clear) begin
            fill_next = '0;
            ovf_next  = 1'b0;
        end else if (wr_en && (wr_char != alt_pkg::CH_NUL)) begin
            if (fill_reg < FILL_W'(LINE_CAP)) begin
                store_en  = 1'b1;
                fill_next = fill_reg + FILL_W'(1);
            end else begin
                ovf_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg <= '0;
            ovf_reg  <= 1'b0;
        end else begin
            fill_reg <= fill_next;
            ovf_reg  <= ovf_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (store_en) begin
            line_store_mem[fill_reg[IDX_W-1:0]] <= wr_char;
        end
        rd_data_reg <= line_store_mem[rd_addr];
    end

    assign rd_data    = rd_data_reg;
    assign fill       = fill_reg;
    assign overflowed = ovf_reg;

endmodule

`default_nettype wire

// ===== rtl/alt_walker.sv =====
// line walk sequencer: up to three sweeps over the line buffer and result emission
`default_nettype none

module alt_walker #(
    parameter int LINE_CAP     = alt_pkg::LINE_CAP_DEF,
    parameter int MAX_OPERANDS = alt_pkg::MAX_OPERANDS_DEF
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              start,
    input  wire logic [$clog2(LINE_CAP+1)-1:0]     fill,
    input  wire logic                              buf_ovf,
    input  wire logic [alt_pkg::MAXNS_W-1:0]       max_nonspace,
    input  wire logic [alt_pkg::MAXLAB_W-1:0]      max_label,
    output logic      [$clog2(LINE_CAP)-1:0]       rd_addr,
    input  wire logic [alt_pkg::CHAR_W-1:0]        rd_data,
    output logic                                   busy,
    output logic                                   res_valid,
    input  wire logic                              res_ready,
    output alt_pkg::alt_result_t                   res
);

    localparam int IDX_W  = $clog2(LINE_CAP);
    localparam int FILL_W = $clog2(LINE_CAP + 1);
    localparam int CW     = (FILL_W > 8) ? FILL_W : 8;
    localparam int OPI_W  = $clog2(MAX_OPERANDS + 1);

    typedef enum logic [9:0] {
        S_IDLE     = 10'b00_0000_0001,
        S_SCAN_A   = 10'b00_0000_0010,
        S_DECIDE_A = 10'b00_0000_0100,
        S_SCAN_B   = 10'b00_0000_1000,
        S_DECIDE_B = 10'b00_0001_0000,
        S_EMIT_LAB = 10'b00_0010_0000,
        S_EMIT_NAM = 10'b00_0100_0000,
        S_SCAN_C   = 10'b00_1000_0000,
        S_EMIT_OP  = 10'b01_0000_0000,
        S_EMIT_ONE = 10'b10_0000_0000
    } state_t;

    typedef enum logic [3:0] {
        P_SKIP1 = 4'b0001,
        P_NAME  = 4'b0010,
        P_SKIP2 = 4'b0100,
        P_OPS   = 4'b1000
    } phase_t;

    state_t state_reg, state_next;
    phase_t phase_reg, phase_next;

    logic                 ev_valid_reg, ev_valid_next;
    logic [FILL_W-1:0]    ev_idx_reg, ev_idx_next;
    logic [FILL_W-1:0]    scan_idx_reg, scan_idx_next;
    logic [FILL_W-1:0]    n_reg, n_next;
    logic                 ovf_reg, ovf_next;
    // first sweep
    logic [FILL_W-1:0]    nonsp_reg, nonsp_next;
    logic                 seen_reg, seen_next;
    logic [FILL_W-1:0]    p0_reg, p0_next;
    logic                 semi_reg, semi_next;
    logic                 q_reg, q_next;
    logic                 colon_found_reg, colon_found_next;
    logic [FILL_W-1:0]    colon_reg, colon_next;
    logic                 before_ws_reg, before_ws_next;
    logic                 after_ws_reg, after_ws_next;
    logic                 prev_ws_reg, prev_ws_next;
    // second sweep
    logic [FILL_W-1:0]    ns_reg, ns_next;
    logic [FILL_W-1:0]    ne_reg, ne_next;
    logic                 dot_reg, dot_next;
    logic [FILL_W-1:0]    os_reg, os_next;
    logic                 inop_reg, inop_next;
    logic                 afc_reg, afc_next;
    logic [FILL_W-1:0]    commas_reg, commas_next;
    logic                 has_lab_reg, has_lab_next;
    logic [alt_pkg::KIND_W-1:0]   kind_reg, kind_next;
    logic [FILL_W-1:0]    count_reg, count_next;
    logic [alt_pkg::STATUS_W-1:0] status_reg, status_next;
    // third sweep
    logic [OPI_W-1:0]     opi_reg, opi_next;
    logic [FILL_W-1:0]    first_reg, first_next;
    logic [FILL_W-1:0]    endp_reg, endp_next;
    logic [FILL_W-1:0]    kept_reg, kept_next;
    logic                 seenop_reg, seenop_next;

    logic              c_ws;
    logic              q_tog;
    logic              issue;
    logic              op_go;
    logic              op_err;
    logic              op_last;
    logic [FILL_W-1:0] ev_idx_inc;
    logic [FILL_W-1:0] lab_len;
    logic [FILL_W-1:0] name_len;
    logic [FILL_W-1:0] commas_inc;

    assign c_ws       = alt_pkg::is_ws(rd_data);
    assign q_tog      = (rd_data == alt_pkg::CH_QUOTE) ? !q_reg : q_reg;
    assign issue      = scan_idx_reg < n_reg;
    assign ev_idx_inc = ev_idx_reg + FILL_W'(1);
    assign lab_len    = colon_reg - p0_reg;
    assign name_len   = ne_reg - ns_reg;
    assign commas_inc = commas_reg + FILL_W'(1);
    assign op_last    = (CW'(opi_reg) + CW'(1)) == CW'(count_reg);
    assign rd_addr    = scan_idx_reg[IDX_W-1:0];
    assign busy       = (state_reg != S_IDLE);

    always_comb begin
        state_next       = state_reg;
        phase_next       = phase_reg;
        ev_valid_next    = 1'b0;
        ev_idx_next      = ev_idx_reg;
        scan_idx_next    = scan_idx_reg;
        n_next           = n_reg;
        ovf_next         = ovf_reg;
        nonsp_next       = nonsp_reg;
        seen_next        = seen_reg;
        p0_next          = p0_reg;
        semi_next        = semi_reg;
        q_next           = q_reg;
        colon_found_next = colon_found_reg;
        colon_next       = colon_reg;
        before_ws_next   = before_ws_reg;
        after_ws_next    = after_ws_reg;
        prev_ws_next     = prev_ws_reg;
        ns_next          = ns_reg;
        ne_next          = ne_reg;
        dot_next         = dot_reg;
        os_next          = os_reg;
        inop_next        = inop_reg;
        afc_next         = afc_reg;
        commas_next      = commas_reg;
        has_lab_next     = has_lab_reg;
        kind_next        = kind_reg;
        count_next       = count_reg;
        status_next      = status_reg;
        opi_next         = opi_reg;
        first_next       = first_reg;
        endp_next        = endp_reg;
        kept_next        = kept_reg;
        seenop_next      = seenop_reg;
        op_go            = 1'b0;
        op_err           = 1'b0;
        res_valid        = 1'b0;
        res              = '0;

        unique case (state_reg)
            S_IDLE: begin
                if (start) begin
                    n_next           = fill;
                    ovf_next         = buf_ovf;
                    scan_idx_next    = '0;
                    nonsp_next       = '0;
                    seen_next        = 1'b0;
                    p0_next          = '0;
                    semi_next        = 1'b0;
                    q_next           = 1'b0;
                    colon_found_next = 1'b0;
                    colon_next       = '0;
                    before_ws_next   = 1'b0;
                    after_ws_next    = 1'b0;
                    prev_ws_next     = 1'b0;
                    state_next       = S_SCAN_A;
                end
            end

            // first sweep: first non-space, non-space count, label colon
            S_SCAN_A: begin
                if (issue) begin
                    ev_valid_next = 1'b1;
                    ev_idx_next   = scan_idx_reg;
                    scan_idx_next = scan_idx_reg + FILL_W'(1);
                end else if (!ev_valid_reg) begin
                    state_next = S_DECIDE_A;
                end
                if (ev_valid_reg) begin
                    if (!c_ws) begin
                        nonsp_next = nonsp_reg + FILL_W'(1);
                        if (!seen_reg) begin
                            seen_next = 1'b1;
                            p0_next   = ev_idx_reg;
                            semi_next = (rd_data == alt_pkg::CH_SEMI);
                        end
                    end
                    if (!colon_found_reg) begin
                        if (rd_data == alt_pkg::CH_QUOTE) begin
                            q_next = !q_reg;
                        end else if (!q_reg && (rd_data == alt_pkg::CH_COLON)) begin
                            colon_found_next = 1'b1;
                            colon_next       = ev_idx_reg;
                            before_ws_next   = prev_ws_reg;
                        end
                    end else if (ev_idx_reg == colon_reg + FILL_W'(1)) begin
                        after_ws_next = c_ws;
                    end
                    prev_ws_next = c_ws;
                end
            end

            S_DECIDE_A: begin
                // start values of the second sweep
                phase_next   = P_SKIP1;
                ns_next      = '0;
                ne_next      = n_reg;
                os_next      = n_reg;
                dot_next     = 1'b0;
                inop_next    = 1'b0;
                afc_next     = 1'b1;
                commas_next  = '0;
                q_next       = 1'b0;
                has_lab_next = colon_found_reg;
                scan_idx_next = colon_found_reg ? colon_reg + FILL_W'(1) : '0;
                state_next   = S_SCAN_B;
                if (!seen_reg || semi_reg) begin
                    status_next = alt_pkg::ST_EMPTY;
                    state_next  = S_EMIT_ONE;
                end else if (ovf_reg || (CW'(nonsp_reg) > CW'(max_nonspace))) begin
                    status_next = alt_pkg::ST_OVERFLOW;
                    state_next  = S_EMIT_ONE;
                end else if (colon_found_reg) begin
                    if (p0_reg == colon_reg) begin
                        status_next = alt_pkg::ST_SYNTAX;
                        state_next  = S_EMIT_ONE;
                    end else if (CW'(lab_len) > CW'(max_label)) begin
                        status_next = alt_pkg::ST_OVERFLOW;
                        state_next  = S_EMIT_ONE;
                    end else if (before_ws_reg || !after_ws_reg
                                 || (colon_reg + FILL_W'(1) >= n_reg)) begin
                        status_next = alt_pkg::ST_SYNTAX;
                        state_next  = S_EMIT_ONE;
                    end
                end
            end

            // second sweep: command name, then operand syntax
            S_SCAN_B: begin
                if (issue) begin
                    ev_valid_next = 1'b1;
                    ev_idx_next   = scan_idx_reg;
                    scan_idx_next = scan_idx_reg + FILL_W'(1);
                end else if (!ev_valid_reg) begin
                    state_next = S_DECIDE_B;
                end
                if (ev_valid_reg) begin
                    unique case (phase_reg)
                        P_SKIP1: begin
                            if (!c_ws) begin
                                ns_next    = ev_idx_reg;
                                dot_next   = (rd_data == alt_pkg::CH_DOT);
                                phase_next = P_NAME;
                            end
                        end
                        P_NAME: begin
                            if (c_ws) begin
                                ne_next    = ev_idx_reg;
                                phase_next = P_SKIP2;
                            end
                        end
                        P_SKIP2: begin
                            if (!c_ws) begin
                                os_next    = ev_idx_reg;
                                phase_next = P_OPS;
                                op_go      = 1'b1;
                            end
                        end
                        P_OPS: begin
                            op_go = 1'b1;
                        end
                        default: begin
                            phase_next = P_SKIP1;
                        end
                    endcase
                    if (op_go) begin
                        q_next = q_tog;
                        if (!q_tog) begin
                            if (rd_data == alt_pkg::CH_COMMA) begin
                                if (!inop_reg && afc_reg) begin
                                    op_err = 1'b1;
                                end else begin
                                    commas_next = commas_inc;
                                    afc_next    = 1'b1;
                                    inop_next   = 1'b0;
                                end
                            end else if (!c_ws) begin
                                if (!afc_reg) begin
                                    op_err = 1'b1;
                                end else begin
                                    inop_next = 1'b1;
                                end
                            end else begin
                                if (inop_reg) begin
                                    afc_next = 1'b0;
                                end
                                inop_next = 1'b0;
                            end
                        end
                    end
                    if (op_err) begin
                        ev_valid_next = 1'b0;
                        status_next   = alt_pkg::ST_SYNTAX;
                        state_next    = S_EMIT_ONE;
                    end
                end
            end

            S_DECIDE_B: begin
                kind_next  = dot_reg ? alt_pkg::KIND_DIRECT : alt_pkg::KIND_INSTR;
                count_next = (phase_reg == P_OPS) ? commas_inc : '0;
                state_next = has_lab_reg ? S_EMIT_LAB : S_EMIT_NAM;
                if ((phase_reg == P_SKIP1) || (dot_reg && (name_len == FILL_W'(1)))) begin
                    status_next = alt_pkg::ST_SYNTAX;
                    state_next  = S_EMIT_ONE;
                end else if ((phase_reg == P_OPS) && ((afc_reg && !inop_reg) || q_reg)) begin
                    status_next = alt_pkg::ST_SYNTAX;
                    state_next  = S_EMIT_ONE;
                end else if ((phase_reg == P_OPS)
                             && (CW'(commas_inc) > CW'(MAX_OPERANDS))) begin
                    status_next = alt_pkg::ST_OVERFLOW;
                    state_next  = S_EMIT_ONE;
                end
            end

            S_EMIT_LAB: begin
                res_valid         = 1'b1;
                res.status        = alt_pkg::ST_OK;
                res.token_kind    = alt_pkg::KIND_LABEL;
                res.token_start   = alt_pkg::START_W'(p0_reg);
                res.token_end     = alt_pkg::END_W'(colon_reg);
                res.kept_length   = alt_pkg::KEPT_W'(lab_len);
                res.operand_count = alt_pkg::COUNT_W'(count_reg);
                res.last          = 1'b0;
                if (res_ready) begin
                    state_next = S_EMIT_NAM;
                end
            end

            S_EMIT_NAM: begin
                res_valid         = 1'b1;
                res.status        = alt_pkg::ST_OK;
                res.token_kind    = kind_reg;
                res.token_start   = alt_pkg::START_W'(ns_reg);
                res.token_end     = alt_pkg::END_W'(ne_reg);
                res.kept_length   = alt_pkg::KEPT_W'(name_len);
                res.operand_count = alt_pkg::COUNT_W'(count_reg);
                res.last          = (count_reg == '0);
                if (res_ready) begin
                    if (count_reg == '0) begin
                        state_next = S_IDLE;
                    end else begin
                        scan_idx_next = os_reg;
                        opi_next      = '0;
                        first_next    = os_reg;
                        endp_next     = os_reg;
                        kept_next     = '0;
                        seenop_next   = 1'b0;
                        q_next        = 1'b0;
                        state_next    = S_SCAN_C;
                    end
                end
            end

            // third sweep: span and kept length of each operand
            S_SCAN_C: begin
                if (issue) begin
                    ev_valid_next = 1'b1;
                    ev_idx_next   = scan_idx_reg;
                    scan_idx_next = scan_idx_reg + FILL_W'(1);
                end else if (!ev_valid_reg) begin
                    state_next = S_EMIT_OP;
                end
                if (ev_valid_reg) begin
                    if ((rd_data == alt_pkg::CH_COMMA) && !q_reg) begin
                        // drop the read in flight, resume after the comma
                        ev_valid_next = 1'b0;
                        scan_idx_next = ev_idx_inc;
                        state_next    = S_EMIT_OP;
                    end else begin
                        q_next = q_tog;
                        if (!c_ws || q_tog) begin
                            kept_next = kept_reg + FILL_W'(1);
                        end
                        if (!c_ws) begin
                            if (!seenop_reg) begin
                                first_next  = ev_idx_reg;
                                seenop_next = 1'b1;
                            end
                            endp_next = ev_idx_inc;
                        end
                    end
                end
            end

            S_EMIT_OP: begin
                res_valid         = 1'b1;
                res.status        = alt_pkg::ST_OK;
                res.token_kind    = alt_pkg::KIND_OPERAND;
                res.operand_index = alt_pkg::OPIDX_W'(opi_reg);
                res.token_start   = alt_pkg::START_W'(first_reg);
                res.token_end     = alt_pkg::END_W'(endp_reg);
                res.kept_length   = alt_pkg::KEPT_W'(kept_reg);
                res.operand_count = alt_pkg::COUNT_W'(count_reg);
                res.last          = op_last;
                if (res_ready) begin
                    if (op_last) begin
                        state_next = S_IDLE;
                    end else begin
                        opi_next    = opi_reg + OPI_W'(1);
                        first_next  = scan_idx_reg;
                        endp_next   = scan_idx_reg;
                        kept_next   = '0;
                        seenop_next = 1'b0;
                        q_next      = 1'b0;
                        state_next  = S_SCAN_C;
                    end
                end
            end

            S_EMIT_ONE: begin
                res_valid  = 1'b1;
                res.status = status_reg;
                res.last   = 1'b1;
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            ev_valid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            ev_valid_reg <= ev_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        phase_reg       <= phase_next;
        ev_idx_reg      <= ev_idx_next;
        scan_idx_reg    <= scan_idx_next;
        n_reg           <= n_next;
        ovf_reg         <= ovf_next;
        nonsp_reg       <= nonsp_next;
        seen_reg        <= seen_next;
        p0_reg          <= p0_next;
        semi_reg        <= semi_next;
        q_reg           <= q_next;
        colon_found_reg <= colon_found_next;
        colon_reg       <= colon_next;
        before_ws_reg   <= before_ws_next;
        after_ws_reg    <= after_ws_next;
        prev_ws_reg     <= prev_ws_next;
        ns_reg          <= ns_next;
        ne_reg          <= ne_next;
        dot_reg         <= dot_next;
        os_reg          <= os_next;
        inop_reg        <= inop_next;
        afc_reg         <= afc_next;
        commas_reg      <= commas_next;
        has_lab_reg     <= has_lab_next;
        kind_reg        <= kind_next;
        count_reg       <= count_next;
        status_reg      <= status_next;
        opi_reg         <= opi_next;
        first_reg       <= first_next;
        endp_reg        <= endp_next;
        kept_reg        <= kept_next;
        seenop_reg      <= seenop_next;
    end

endmodule

`default_nettype wire

// ===== rtl/assembly_line_tokenizer.sv =====
// assembly line tokenizer top level
//
// s_ channel: one request per character in s_tdata[7:0]; s_tlast high marks
// end of line (no character) and starts the walk. A zero character is dropped,
// characters beyond the buffer capacity set an overflow mark for the line.
// m_ channel: one request per token (label, command name, each operand), or a
// single request carrying an empty, syntax error or overflow status; m_tlast
// marks the final request of the line.
// Loading takes one character per cycle while no walk runs. The walk makes up
// to three sweeps over the line buffer through its single registered read
// port; the first sweep and a completed second sweep are each followed by a
// decision step, and the operand sweep starts at the first operand. Each
// result passes through the output register to m_tvalid.
// No character is taken while a walk runs.
// A stalled receiver holds the walk at its current result; the output register
// lets the next line load while the final result of a line still waits.
// Reset empties the buffer and sets the limits to 80 and 31; the buffer memory
// itself is not cleared, so no clearing pass follows reset.
`default_nettype none
`include "assembly_line_tokenizer_defines.svh"

module assembly_line_tokenizer #(
    parameter int LINE_CAP     = alt_pkg::LINE_CAP_DEF,
    parameter int MAX_OPERANDS = alt_pkg::MAX_OPERANDS_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [alt_pkg::CHAR_W-1:0]    s_tdata,   // [7:0] char_code
    input  wire logic                          s_tlast,   // end_of_line
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // [1:0] status, [5:2] operand_index, [12:6] token_start, [20:13] token_end,
    // [28:21] kept_length, [33:29] operand_count, [39:34] zero
    output logic      [alt_pkg::TDATA_W-1:0]   m_tdata,
    output logic      [alt_pkg::KIND_W-1:0]    m_tuser,   // [2:0] token_kind
    output logic                               m_tlast,   // last
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [alt_pkg::APB_AW-1:0]    paddr,
    input  wire logic [alt_pkg::APB_DW-1:0]    pwdata,
    output logic      [alt_pkg::APB_DW-1:0]    prdata,
    output logic                               pready
);

    localparam int IDX_W  = $clog2(LINE_CAP);
    localparam int FILL_W = $clog2(LINE_CAP + 1);

    logic [alt_pkg::MAXNS_W-1:0]  max_ns_reg, max_ns_next;
    logic [alt_pkg::MAXLAB_W-1:0] max_lab_reg, max_lab_next;

    logic                          m_tvalid_reg, m_tvalid_next;
    logic [alt_pkg::TDATA_W-1:0]   m_tdata_reg, m_tdata_next;
    logic [alt_pkg::KIND_W-1:0]    m_tuser_reg, m_tuser_next;
    logic                          m_tlast_reg, m_tlast_next;

    logic                          in_take;
    logic                          char_wr;
    logic                          line_end;
    logic                          cfg_wr;
    logic                          walk_busy;
    logic [IDX_W-1:0]              rd_addr;
    logic [alt_pkg::CHAR_W-1:0]    rd_data;
    logic [FILL_W-1:0]             fill;
    logic                          buf_ovf;
    logic                          res_valid;
    logic                          res_ready;
    alt_pkg::alt_result_t          res;

    // the buffer is only written between walks, so reads and writes never meet
    assign s_tready = !walk_busy;
    assign in_take  = s_tvalid && s_tready;
    assign char_wr  = in_take && !s_tlast;
    assign line_end = in_take && s_tlast;

    alt_line_buf #(
        .LINE_CAP (LINE_CAP)
    ) u_line_buf (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .wr_en      (char_wr),
        .wr_char    (s_tdata),
        .line_clear (line_end),
        .rd_addr    (rd_addr),
        .rd_data    (rd_data),
        .fill       (fill),
        .overflowed (buf_ovf)
    );

    alt_walker #(
        .LINE_CAP     (LINE_CAP),
        .MAX_OPERANDS (MAX_OPERANDS)
    ) u_walker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .start        (line_end),
        .fill         (fill),
        .buf_ovf      (buf_ovf),
        .max_nonspace (max_ns_reg),
        .max_label    (max_lab_reg),
        .rd_addr      (rd_addr),
        .rd_data      (rd_data),
        .busy         (walk_busy),
        .res_valid    (res_valid),
        .res_ready    (res_ready),
        .res          (res)
    );

    // output register
    assign res_ready = !m_tvalid_reg || m_tready;

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        m_tlast_next  = m_tlast_reg;
        if (res_valid && res_ready) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = {{alt_pkg::TDATA_PAD{1'b0}}, res.operand_count, res.kept_length,
                             res.token_end, res.token_start, res.operand_index, res.status};
            m_tuser_next  = res.token_kind;
            m_tlast_next  = res.last;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    // configuration port
    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;

    always_comb begin
        max_ns_next  = max_ns_reg;
        max_lab_next = max_lab_reg;
        if (cfg_wr) begin
            unique case (paddr[2])
                alt_pkg::REG_MAX_NONSPACE: max_ns_next  = pwdata[alt_pkg::MAXNS_W-1:0];
                alt_pkg::REG_MAX_LABEL:    max_lab_next = pwdata[alt_pkg::MAXLAB_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            alt_pkg::REG_MAX_NONSPACE: prdata = alt_pkg::APB_DW'(max_ns_reg);
            alt_pkg::REG_MAX_LABEL:    prdata = alt_pkg::APB_DW'(max_lab_reg);
            default:                   prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
            max_ns_reg   <= alt_pkg::MAX_NONSPACE_RST;
            max_lab_reg  <= alt_pkg::MAX_LABEL_RST;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
            max_ns_reg   <= max_ns_next;
            max_lab_reg  <= max_lab_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
        m_tlast_reg <= m_tlast_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

    `ALT_ASSERT_SAME(a_no_char_during_walk, res_valid, !s_tready, "character taken during walk")
    `ALT_ASSERT_NEXT(a_eol_starts_walk, line_end, !s_tready, "end of line did not start walk")
    `ALT_ASSERT_NEXT(a_last_ends_walk, res_valid && res_ready && res.last, s_tready, "walk hung")

endmodule

`default_nettype wire
